// File: hw/rtl/slist_pkg.sv
// Shared constants and controller/datapath interface types for the sorted list core.
package slist_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef struct packed {
        logic             insert;
        logic             load;
        logic [IDX_W-1:0] idx;
        logic             last;
        logic             reject;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             full;
        logic             out_free;
    } sts_t;

endpackage

// File: hw/rtl/slist_ctrl.sv
// Controller: takes one value, then walks the list index out one beat at a time.
module slist_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  slist_pkg::sts_t      sts,
    output slist_pkg::cmd_t      cmd
);

    typedef enum logic [1:0]
    {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [slist_pkg::IDX_W-1:0] idx_reg;
    logic [slist_pkg::IDX_W-1:0] idx_next;
    logic                        rej_reg;
    logic                        rej_next;
    logic                        accept;
    logic                        last;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign last     = ({1'b0, idx_reg} + slist_pkg::CNT_W'(1)) == sts.count;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        rej_next   = rej_reg;
        cmd.insert = 1'b0;
        cmd.load   = 1'b0;
        cmd.idx    = idx_reg;
        cmd.last   = last;
        cmd.reject = rej_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.insert = !sts.full;
                    rej_next   = sts.full;
                    idx_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load = 1'b1;
                    if (last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + slist_pkg::IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            rej_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            rej_reg   <= rej_next;
        end
    end

endmodule

// File: hw/rtl/slist_dp.sv
// Datapath: insertion shift array of entries, entry count and the output register.
module slist_dp
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic signed [slist_pkg::DATA_W-1:0] new_value,
    input  slist_pkg::cmd_t                    cmd,
    output slist_pkg::sts_t                    sts,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [3:0]                         position,
    output logic signed [31:0]                 entry_value,
    output logic                               is_last,
    output logic                               rejected
);

    logic signed [slist_pkg::DATA_W-1:0] entries_reg  [slist_pkg::DEPTH];
    logic signed [slist_pkg::DATA_W-1:0] entries_next [slist_pkg::DEPTH];
    logic [slist_pkg::DEPTH-1:0]         gt;
    logic [slist_pkg::CNT_W-1:0]         count_reg;
    logic [slist_pkg::CNT_W-1:0]         count_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic [3:0]                          pos_reg;
    logic signed [31:0]                  val_reg;
    logic                                last_reg;
    logic                                rej_reg;

    // Entries strictly greater than the new value move up one place.
    always_comb
    begin
        for (int k = 0; k < slist_pkg::DEPTH; k++)
        begin
            gt[k] = (slist_pkg::CNT_W'(k) < count_reg) && (entries_reg[k] > new_value);
        end
    end

    always_comb
    begin
        for (int k = 0; k < slist_pkg::DEPTH; k++)
        begin
            entries_next[k] = entries_reg[k];
            if (k > 0 && gt[(k > 0) ? k - 1 : 0])
            begin
                entries_next[k] = entries_reg[(k > 0) ? k - 1 : 0];
            end
            else if (gt[k] || slist_pkg::CNT_W'(k) == count_reg)
            begin
                entries_next[k] = new_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            for (int k = 0; k < slist_pkg::DEPTH; k++)
            begin
                entries_reg[k] <= entries_next[k];
            end
        end
    end

    assign count_next = cmd.insert ? count_reg + slist_pkg::CNT_W'(1) : count_reg;

    assign sts.count    = count_reg;
    assign sts.full     = (count_reg == slist_pkg::CNT_W'(slist_pkg::DEPTH));
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid_next = cmd.load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pos_reg  <= 4'(cmd.idx);
            val_reg  <= entries_reg[cmd.idx];
            last_reg <= cmd.last;
            rej_reg  <= cmd.reject;
        end
    end

    assign out_valid   = out_valid_reg;
    assign position    = pos_reg;
    assign entry_value = val_reg;
    assign is_last     = last_reg;
    assign rejected    = rej_reg;

endmodule

// File: hw/rtl/sorted_list_insert_core.sv
// Sorted list insertion core: 16 signed entries kept in ascending order.
// Flow: a value is accepted in the idle state, then the whole list is walked out, and no new
// value is taken until the last entry is loaded into the output register, set by the
// single read port that walks the list one entry per beat through the output register.
// Reset: async active low clears the entry count and output valid; entry storage is not cleared.
module sorted_list_insert_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] new_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         position,
    output logic signed [31:0] entry_value,
    output logic               is_last,
    output logic               rejected
);

    slist_pkg::cmd_t cmd;
    slist_pkg::sts_t sts;

    slist_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    slist_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .new_value   (new_value),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .position    (position),
        .entry_value (entry_value),
        .is_last     (is_last),
        .rejected    (rejected)
    );

endmodule

// File: hw/rtl/slist_checker.sv
// Port-level checker for the sorted list core, bound to the top level.
module slist_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [3:0]         position,
    input logic signed [31:0] entry_value,
    input logic               is_last,
    input logic               rejected
);

    // Stalled output beat holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(entry_value) && $stable(position))
        else $error("output beat changed while stalled");

    // No new value is taken while a list is still being walked out.
    a_busy_mid_list: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_last |-> !in_ready)
        else $error("input ready during list emission");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("back to back accept");

    // A reject only happens on a full list, so its final beat is the top slot.
    a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected && is_last |-> position == 4'hF)
        else $error("reject on a list that was not full");

endmodule

bind sorted_list_insert_core slist_checker u_slist_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .position    (position),
    .entry_value (entry_value),
    .is_last     (is_last),
    .rejected    (rejected)
);

// File: test/tb_top.sv
// Self-checking testbench for the sorted list insertion core.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;
    localparam int MAX_REPORTS = 50;

    typedef struct packed {
        logic [slist_pkg::IDX_W-1:0]         position;
        logic signed [slist_pkg::DATA_W-1:0] entry_value;
        logic                                is_last;
        logic                                rejected;
    } list_entry_t;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_HALF,
        RX_SPARSE,
        RX_PATTERN
    } rx_mode_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic signed [slist_pkg::DATA_W-1:0] new_value = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic [slist_pkg::IDX_W-1:0]         position;
    logic signed [slist_pkg::DATA_W-1:0] entry_value;
    logic                                is_last;
    logic                                rejected;

    logic signed [slist_pkg::DATA_W-1:0] stored_list[$];
    list_entry_t                         expected_entries[$];
    int                                  error_count = 0;
    int                                  burst_left = 0;
    int                                  idle_cycles = 0;
    bit                                  rx_hold_req = 1'b0;
    int                                  rx_hold_left = 0;
    int                                  rx_phase = 0;
    rx_mode_t                            rx_mode = RX_ALWAYS;

    sorted_list_insert_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .new_value  (new_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .position   (position),
        .entry_value(entry_value),
        .is_last    (is_last),
        .rejected   (rejected)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTS)
            $display("%0t ns: mismatch: %s", $time, msg);
        error_count++;
    endtask

    // Insert into the ordered copy and queue the list the block should emit.
    task automatic predict_list(input logic signed [slist_pkg::DATA_W-1:0] value);
        int          slot;
        bit          full;
        list_entry_t entry;
        full = (stored_list.size() >= slist_pkg::DEPTH);
        if (!full)
        begin
            slot = 0;
            while (slot < stored_list.size() && !(value < stored_list[slot]))
                slot++;
            stored_list.insert(slot, value);
        end
        for (int k = 0; k < stored_list.size(); k++)
        begin
            entry.position    = k[slist_pkg::IDX_W-1:0];
            entry.entry_value = stored_list[k];
            entry.is_last     = (k == stored_list.size() - 1);
            entry.rejected    = full;
            expected_entries.push_back(entry);
        end
    endtask

    // Output check first, so a beat at this edge never meets this edge's prediction.
    always @(posedge clk)
    begin
        list_entry_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_entries.size() == 0)
                report_mismatch($sformatf("unexpected beat pos %0d value %0d",
                                          position, entry_value));
            else
            begin
                want = expected_entries.pop_front();
                if (position !== want.position)
                    report_mismatch($sformatf("position %0d, want %0d",
                                              position, want.position));
                if (entry_value !== want.entry_value)
                    report_mismatch($sformatf("pos %0d value %0d, want %0d",
                                              want.position, entry_value, want.entry_value));
                if (is_last !== want.is_last)
                    report_mismatch($sformatf("pos %0d is_last %b, want %b",
                                              want.position, is_last, want.is_last));
                if (rejected !== want.rejected)
                    report_mismatch($sformatf("pos %0d rejected %b, want %b",
                                              want.position, rejected, want.rejected));
            end
        end
        if (rst_n && in_valid && in_ready)
            predict_list(new_value);
    end

    // Receiver: switches at random among four stall patterns; long hold on request.
    always @(posedge clk)
    begin
        if (rx_hold_req)
        begin
            rx_hold_req  = 1'b0;
            rx_hold_left = HOLD_CYCLES;
        end
        rx_phase++;
        if (rx_phase % 64 == 0)
            rx_mode = rx_mode_t'($urandom_range(0, 3));
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_ALWAYS:  out_ready <= 1'b1;
                RX_HALF:    out_ready <= $urandom_range(0, 1);
                RX_SPARSE:  out_ready <= ($urandom_range(0, 3) == 0);
                RX_PATTERN: out_ready <= ((rx_phase % 5) < 3);
                default:    out_ready <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_value(input logic signed [slist_pkg::DATA_W-1:0] value);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        new_value <= value;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Step past the edge first so the last accepted beat is already predicted.
    task automatic wait_drained();
        in_valid <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (expected_entries.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic signed [slist_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return {1'b0, {(slist_pkg::DATA_W-1){1'b1}}};
            1:       return {1'b1, {(slist_pkg::DATA_W-1){1'b0}}};
            2:       return $signed($urandom_range(0, 32)) - 16;
            default: return $urandom;
        endcase
    endfunction

    // Head, tail and sign extremes on a growing list.
    task automatic test_extremes();
        send_value(0);
        send_value(32'sh7fff_ffff);
        send_value(32'sh8000_0000);
        send_value(-1);
        send_value(1);
    endtask

    // Equal values land after the stored copies.
    task automatic test_equal_values();
        send_value(32'sh7fff_ffff);
        send_value(32'sh8000_0000);
        send_value(0);
        send_value(5);
        send_value(5);
    endtask

    task automatic test_full_list();
        int fill;
        wait_drained();
        fill = slist_pkg::DEPTH - stored_list.size();
        for (int n = 0; n < fill; n++)
            send_value($urandom);
        wait_drained();
        send_value(32'sh8000_0000);
        send_value(32'sh7fff_ffff);
    endtask

    // Receiver holds off while full lists keep arriving, so the input stalls.
    task automatic test_backpressure();
        wait_drained();
        rx_hold_req = 1'b1;
        for (int n = 0; n < 10; n++)
            send_value(pick_value());
        wait_drained();
    endtask

    task automatic test_random_stream();
        for (int n = 0; n < 140; n++)
        begin
            if (n % 50 == 49)
                wait_drained();
            send_value(pick_value());
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_equal_values();
        test_full_list();
        test_backpressure();
        test_random_stream();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_entries.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
